>>> rtl/gha_pkg.sv
package gha_pkg;

  localparam int unsigned SLOT_COUNT = 1024;
  localparam int unsigned GEN_BITS   = 16;
  localparam int unsigned IDX_W      = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W      = IDX_W + 1;

  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_DESTROY = 2'd1;
  localparam logic [1:0] OP_CHECK   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_STALE = 2'd2;

  // One word of the slot table
  typedef struct packed {
    logic                alive;
    logic [GEN_BITS-1:0] gen;
  } slot_entry_t;

  // One word of the free stack: index plus the generation it will be granted with
  typedef struct packed {
    logic [GEN_BITS-1:0] gen;
    logic [IDX_W-1:0]    idx;
  } stack_entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic commit;
  } dp_cmd_t;

endpackage

>>> rtl/gha_ctrl.sv
module gha_ctrl
  import gha_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  output logic    busy_o,
  output dp_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;

  // Take a beat in idle, execute it in the next cycle
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start_i) state_d = S_EXEC;
      S_EXEC: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o        = (state_q == S_EXEC);
  assign cmd_o.capture = start_i && (state_q == S_IDLE);
  assign cmd_o.commit  = (state_q == S_EXEC);

`ifndef SYNTH
  a_exec_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |=> state_q == S_IDLE)
    else $error("execute state held longer than one cycle");

  a_capture_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> busy_o && cmd_o.commit)
    else $error("accepted beat not executed in the next cycle");

  a_no_capture_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.capture && cmd_o.commit))
    else $error("capture while executing");
`endif

endmodule

>>> rtl/gha_datapath.sv
module gha_datapath
  import gha_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  input  logic [1:0]          opcode_i,
  input  logic [IDX_W-1:0]    slot_index_i,
  input  logic [GEN_BITS-1:0] slot_generation_i,
  output logic                done_o,
  output logic [1:0]          status_o,
  output logic [IDX_W-1:0]    granted_index_o,
  output logic [GEN_BITS-1:0] granted_generation_o,
  output logic                is_alive_o
);

  slot_entry_t  slot_mem  [SLOT_COUNT];
  stack_entry_t stack_mem [SLOT_COUNT];

  logic [1:0]          op_q;
  logic [IDX_W-1:0]    idx_q;
  logic [GEN_BITS-1:0] gen_q;
  slot_entry_t         slot_rd_q;
  stack_entry_t        stack_rd_q;

  logic [CNT_W-1:0] free_count_q, free_count_d;
  logic [CNT_W-1:0] next_fresh_q, next_fresh_d;
  logic [CNT_W-1:0] pop_count;

  logic                slot_we;
  logic [IDX_W-1:0]    slot_wa;
  slot_entry_t         slot_wd;
  logic                stack_we;
  stack_entry_t        stack_wd;

  logic                touched;
  logic                rd_alive;
  logic [GEN_BITS-1:0] rd_gen;
  logic [GEN_BITS-1:0] gen_inc;
  logic                live;

  logic                done_q;
  logic [1:0]          status_q, status_d;
  logic [IDX_W-1:0]    gidx_q, gidx_d;
  logic [GEN_BITS-1:0] ggen_q, ggen_d;
  logic                alive_q, alive_d;

  assign pop_count = free_count_q - CNT_W'(1);

  // Latch the beat and read both memories at the accept edge
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= opcode_i;
      idx_q      <= slot_index_i;
      gen_q      <= slot_generation_i;
      slot_rd_q  <= slot_mem[slot_index_i];
      stack_rd_q <= stack_mem[pop_count[IDX_W-1:0]];
    end
  end

  // Slots at or above the fresh pointer were never written: they read as cleared
  assign touched  = {1'b0, idx_q} < next_fresh_q;
  assign rd_alive = touched && slot_rd_q.alive;
  assign rd_gen   = touched ? slot_rd_q.gen : '0;
  assign gen_inc  = rd_gen + GEN_BITS'(1);
  assign live     = (idx_q != '0) && rd_alive && (rd_gen == gen_q);

  // Execute the operation and form the result
  always_comb begin
    free_count_d = free_count_q;
    next_fresh_d = next_fresh_q;
    slot_we      = 1'b0;
    slot_wa      = idx_q;
    slot_wd      = '{alive: 1'b0, gen: gen_inc};
    stack_we     = 1'b0;
    stack_wd     = '{gen: gen_inc, idx: idx_q};
    status_d     = ST_OK;
    gidx_d       = '0;
    ggen_d       = '0;
    alive_d      = 1'b0;
    if (cmd_i.commit) begin
      unique case (op_q)
        OP_CREATE: begin
          priority if (free_count_q != '0) begin
            // pop the most recently freed slot
            free_count_d = pop_count;
            if (stack_rd_q.idx != '0) begin
              slot_we = 1'b1;
              slot_wa = stack_rd_q.idx;
              slot_wd = '{alive: 1'b1, gen: stack_rd_q.gen};
              gidx_d  = stack_rd_q.idx;
              ggen_d  = stack_rd_q.gen;
            end else begin
              status_d = ST_FULL;
            end
          end else if (next_fresh_q < CNT_W'(SLOT_COUNT)) begin
            // take a never-used slot at generation zero
            next_fresh_d = next_fresh_q + CNT_W'(1);
            slot_we      = 1'b1;
            slot_wa      = next_fresh_q[IDX_W-1:0];
            slot_wd      = '{alive: 1'b1, gen: '0};
            gidx_d       = next_fresh_q[IDX_W-1:0];
          end else begin
            status_d = ST_FULL;
          end
        end
        OP_DESTROY: begin
          if (live) begin
            slot_we = 1'b1;
            if (free_count_q < CNT_W'(SLOT_COUNT)) begin
              stack_we     = 1'b1;
              free_count_d = free_count_q + CNT_W'(1);
            end
          end else begin
            status_d = ST_STALE;
          end
        end
        OP_CHECK: alive_d = live;
        default:  status_d = ST_STALE;
      endcase
    end
  end

  // Write the memories at the commit edge
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (stack_we) begin
      stack_mem[free_count_q[IDX_W-1:0]] <= stack_wd;
    end
  end

  // Hold the counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_count_q <= '0;
      next_fresh_q <= CNT_W'(1);
      done_q       <= 1'b0;
    end else begin
      free_count_q <= free_count_d;
      next_fresh_q <= next_fresh_d;
      done_q       <= cmd_i.commit;
    end
  end

  // Register the result beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= status_d;
      gidx_q   <= gidx_d;
      ggen_q   <= ggen_d;
      alive_q  <= alive_d;
    end
  end

  assign done_o               = done_q;
  assign status_o             = status_q;
  assign granted_index_o      = gidx_q;
  assign granted_generation_o = ggen_q;
  assign is_alive_o           = alive_q;

`ifndef SYNTH
  a_fresh_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_fresh_q != '0 && next_fresh_q <= CNT_W'(SLOT_COUNT))
    else $error("fresh slot pointer out of range");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_count_q < next_fresh_q)
    else $error("free stack holds more slots than were ever used");

  a_grant_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && op_q == OP_CREATE && status_q == ST_OK |-> gidx_q != '0)
    else $error("create granted the reserved slot");
`endif

endmodule

>>> rtl/generational_handle_allocator_top.sv
// Generational handle allocator. Raise start_i with an opcode (create,
// destroy, check) while busy_o is low; the beat is taken at that edge. The
// next cycle executes it, and the result is on the result ports in the cycle
// after that, for exactly one cycle with done_o high; it is taken at the edge
// that ends that cycle. The receiver cannot stall, so it must take every
// result in the cycle it is shown. The memories are read at the accept edge
// and written back at the end of the execute cycle; busy_o is high in the
// execute cycle, and a new beat may be accepted at the edge that ends the
// result cycle. The slot table needs no clearing pass after reset: slots past
// the fresh pointer read as dead at generation zero.
module generational_handle_allocator_top
  import gha_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          opcode_i,
  input  logic [IDX_W-1:0]    slot_index_i,
  input  logic [GEN_BITS-1:0] slot_generation_i,
  output logic                done_o,
  output logic [1:0]          status_o,
  output logic [IDX_W-1:0]    granted_index_o,
  output logic [GEN_BITS-1:0] granted_generation_o,
  output logic                is_alive_o
);

  dp_cmd_t cmd;

  gha_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  gha_datapath u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .opcode_i             (opcode_i),
    .slot_index_i         (slot_index_i),
    .slot_generation_i    (slot_generation_i),
    .done_o               (done_o),
    .status_o             (status_o),
    .granted_index_o      (granted_index_o),
    .granted_generation_o (granted_generation_o),
    .is_alive_o           (is_alive_o)
  );

endmodule
